// ===== rtl/psd_pkg.sv =====
// Shared constants and types for the point-to-segment closest distance unit.
`timescale 1ns / 1ps

package psd_pkg;

  // Default coordinate width (signed, fixed point)
  localparam int COORD_BITS_DEF = 20;
  // Default number of fraction bits in the projection parameter t
  localparam int T_BITS_DEF = 16;

  // How t is resolved once the dot product and squared length are known
  typedef enum logic [1:0] {
    T_ZERO,   // degenerate segment or projection at or before A
    T_FULL,   // projection at or beyond B
    T_DIV     // inside the segment, quotient from the divider
  } t_class_t;

endpackage

// ===== rtl/psd_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit per request.
`timescale 1ns / 1ps

module psd_div_cell #(
  parameter int DW = 42,
  parameter int QW = 16,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] in_rem,
  input  logic [DW-1:0] in_den,
  input  logic [QW-1:0] in_quo,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] out_rem,
  output logic [DW-1:0] out_den,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic [DW:0]   rem_sh;
  logic          take;
  logic [DW:0]   rem_sub;
  logic [DW-1:0] rem_next;
  logic [QW-1:0] quo_next;

  // Shift in a zero, trial subtract the divisor
  always_comb begin
    rem_sh   = {in_rem, 1'b0};
    take     = (rem_sh >= {1'b0, in_den});
    rem_sub  = rem_sh - {1'b0, in_den};
    rem_next = take ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
    quo_next = {in_quo[QW-2:0], take};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rem  <= rem_next;
      out_den  <= in_den;
      out_quo  <= quo_next;
      out_side <= in_side;
    end
  end

endmodule

// ===== rtl/psd_sqrt_cell.sv =====
// One digit-by-digit square root cell: resolves one root bit per request.
`timescale 1ns / 1ps

module psd_sqrt_cell #(
  parameter int XW = 42,
  parameter int SW = 8,
  localparam int RW = XW / 2,
  localparam int EW = RW + 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [XW-1:0] in_x,
  input  logic [RW-1:0] in_root,
  input  logic [EW-1:0] in_rem,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [XW-1:0] out_x,
  output logic [RW-1:0] out_root,
  output logic [EW-1:0] out_rem,
  output logic [SW-1:0] out_side
);

  logic [EW-1:0] rem_in2;
  logic [EW-1:0] trial;
  logic          take;
  logic [EW-1:0] rem_next;
  logic [RW-1:0] root_next;
  logic [XW-1:0] x_next;

  // Bring down the next two radicand bits, trial subtract 4*root+1
  always_comb begin
    rem_in2   = {in_rem[EW-3:0], in_x[XW-1:XW-2]};
    trial     = {1'b0, in_root, 2'b01};
    take      = (rem_in2 >= trial);
    rem_next  = take ? (rem_in2 - trial) : rem_in2;
    root_next = {in_root[RW-2:0], take};
    x_next    = {in_x[XW-3:0], 2'b00};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_x    <= x_next;
      out_root <= root_next;
      out_rem  <= rem_next;
      out_side <= in_side;
    end
  end

endmodule

// ===== rtl/point_segment_closest_distance_unit.sv =====
// Top level: closest point on a 3D segment, its parameter t and distance.
// Usage:
//   Input channel (in_valid / in_stall) carries segment ends A, B and the
//   query point P, signed fixed point. A request is taken at a rising edge
//   with in_valid high and in_stall low. Output channel (out_valid /
//   out_stall) returns t (unsigned Q1.T_BITS, 2^T_BITS means B), the closest
//   point, the squared distance and its floor square root.
//   The pipeline, in order: three stages form the dot product and squared
//   length, T_BITS divider cells give one quotient bit each, four stages
//   form the closest point and the squared distance, and COORD_BITS + 1
//   root cells give one root bit each.
//   Throughput is one request per cycle while out_stall is low; every
//   stage holds one request. When the receiver stalls, the chain keeps
//   filling empty stages behind the held result, and in_stall rises only
//   once the stage behind the inputs is full.
//   Reset (rst, synchronous) empties every stage; no result is in flight.
`timescale 1ns / 1ps

module point_segment_closest_distance_unit #(
  parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF,
  parameter int T_BITS     = psd_pkg::T_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  end_a_x,
  input  logic signed [COORD_BITS-1:0]  end_a_y,
  input  logic signed [COORD_BITS-1:0]  end_a_z,
  input  logic signed [COORD_BITS-1:0]  end_b_x,
  input  logic signed [COORD_BITS-1:0]  end_b_y,
  input  logic signed [COORD_BITS-1:0]  end_b_z,
  input  logic signed [COORD_BITS-1:0]  query_x,
  input  logic signed [COORD_BITS-1:0]  query_y,
  input  logic signed [COORD_BITS-1:0]  query_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [T_BITS:0]               param_t,
  output logic signed [COORD_BITS-1:0]  near_x,
  output logic signed [COORD_BITS-1:0]  near_y,
  output logic signed [COORD_BITS-1:0]  near_z,
  output logic [2*COORD_BITS+1:0]       dist_squared,
  output logic [COORD_BITS:0]           dist_root
);

  import psd_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;           // difference width
  localparam int LW   = 2 * DW;           // squared length width
  localparam int TW   = T_BITS + 1;       // clamped t width
  localparam int PRW  = DW + TW + 1;      // ab * t product width
  localparam int NW   = CW + 2;           // closest point / delta width
  localparam int XW   = 2 * CW + 2;       // squared distance width
  localparam int RW   = XW / 2;           // root width
  localparam int EW   = RW + 3;           // root remainder width
  localparam int DSW  = 2 + 6 * CW + 3 * DW;
  localparam int SSW  = TW + 3 * CW + XW;

  // ---------------- stage 1: differences ----------------
  logic                  v1, rdy1;
  logic signed [CW-1:0]  s1_a  [3];
  logic signed [CW-1:0]  s1_p  [3];
  logic signed [DW-1:0]  s1_ab [3];
  logic signed [DW-1:0]  s1_ap [3];
  logic signed [CW-1:0]  in_a  [3];
  logic signed [CW-1:0]  in_b  [3];
  logic signed [CW-1:0]  in_p  [3];

  always_comb begin
    in_a[0] = end_a_x;  in_a[1] = end_a_y;  in_a[2] = end_a_z;
    in_b[0] = end_b_x;  in_b[1] = end_b_y;  in_b[2] = end_b_z;
    in_p[0] = query_x;  in_p[1] = query_y;  in_p[2] = query_z;
  end

  logic v2, rdy2;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      for (int i = 0; i < 3; i++) begin
        s1_a[i]  <= in_a[i];
        s1_p[i]  <= in_p[i];
        s1_ab[i] <= DW'(in_b[i]) - DW'(in_a[i]);
        s1_ap[i] <= DW'(in_p[i]) - DW'(in_a[i]);
      end
    end
  end

  // ---------------- stage 2: per-axis products ----------------
  logic signed [CW-1:0]  s2_a  [3];
  logic signed [CW-1:0]  s2_p  [3];
  logic signed [DW-1:0]  s2_ab [3];
  logic signed [LW-1:0]  s2_sq [3];
  logic signed [LW-1:0]  s2_dp [3];
  logic v3, rdy3;
  assign rdy2 = !v2 || rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      for (int i = 0; i < 3; i++) begin
        s2_a[i]  <= s1_a[i];
        s2_p[i]  <= s1_p[i];
        s2_ab[i] <= s1_ab[i];
        s2_sq[i] <= s1_ab[i] * s1_ab[i];
        s2_dp[i] <= s1_ap[i] * s1_ab[i];
      end
    end
  end

  // ---------------- stage 3: squared length and dot product ----------------
  logic signed [CW-1:0]  s3_a  [3];
  logic signed [CW-1:0]  s3_p  [3];
  logic signed [DW-1:0]  s3_ab [3];
  logic [LW-1:0]         s3_len;
  logic signed [LW:0]    s3_dot;

  logic          div_v   [T_BITS+1];
  logic          div_rdy [T_BITS+1];
  logic [LW-1:0] div_rem [T_BITS+1];
  logic [LW-1:0] div_den [T_BITS+1];
  logic [T_BITS-1:0] div_quo [T_BITS+1];
  logic [DSW-1:0] div_side [T_BITS+1];

  assign rdy3 = !v3 || div_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      for (int i = 0; i < 3; i++) begin
        s3_a[i]  <= s2_a[i];
        s3_p[i]  <= s2_p[i];
        s3_ab[i] <= s2_ab[i];
      end
      s3_len <= s2_sq[0][LW-1:0] + s2_sq[1][LW-1:0] + s2_sq[2][LW-1:0];
      s3_dot <= (LW+1)'(s2_dp[0]) + (LW+1)'(s2_dp[1]) + (LW+1)'(s2_dp[2]);
    end
  end

  // Classify t and seed the divider
  t_class_t s3_cls;
  always_comb begin
    if (s3_len == '0 || s3_dot[LW] || s3_dot == '0) begin
      s3_cls = T_ZERO;
    end else if (s3_dot[LW-1:0] >= s3_len) begin
      s3_cls = T_FULL;
    end else begin
      s3_cls = T_DIV;
    end
  end

  assign div_v[0]    = v3;
  assign div_rem[0]  = (s3_cls == T_DIV) ? s3_dot[LW-1:0] : '0;
  assign div_den[0]  = s3_len;
  assign div_quo[0]  = '0;
  assign div_side[0] = {s3_cls, s3_a[0], s3_a[1], s3_a[2], s3_p[0], s3_p[1], s3_p[2],
                        s3_ab[0], s3_ab[1], s3_ab[2]};

  // ---------------- divider chain: one quotient bit per cell ----------------
  for (genvar g = 0; g < T_BITS; g++) begin : g_div
    psd_div_cell #(
      .DW (LW),
      .QW (T_BITS),
      .SW (DSW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (div_v[g]),
      .in_ready  (div_rdy[g]),
      .in_rem    (div_rem[g]),
      .in_den    (div_den[g]),
      .in_quo    (div_quo[g]),
      .in_side   (div_side[g]),
      .out_valid (div_v[g+1]),
      .out_ready (div_rdy[g+1]),
      .out_rem   (div_rem[g+1]),
      .out_den   (div_den[g+1]),
      .out_quo   (div_quo[g+1]),
      .out_side  (div_side[g+1])
    );
  end

  // Unpack the divider side band
  t_class_t              dv_cls;
  logic signed [CW-1:0]  dv_a  [3];
  logic signed [CW-1:0]  dv_p  [3];
  logic signed [DW-1:0]  dv_ab [3];
  logic [TW-1:0]         dv_t;

  always_comb begin
    {dv_cls, dv_a[0], dv_a[1], dv_a[2], dv_p[0], dv_p[1], dv_p[2],
     dv_ab[0], dv_ab[1], dv_ab[2]} = div_side[T_BITS];
    unique case (dv_cls)
      T_ZERO:  dv_t = '0;
      T_FULL:  dv_t = TW'(1) << T_BITS;
      T_DIV:   dv_t = {1'b0, div_quo[T_BITS]};
      default: dv_t = '0;
    endcase
  end

  // ---------------- stage 4: (B-A) * t ----------------
  logic                  v4, rdy4;
  logic signed [CW-1:0]  s4_a    [3];
  logic signed [CW-1:0]  s4_p    [3];
  logic signed [PRW-1:0] s4_prod [3];
  logic [TW-1:0]         s4_t;
  logic                  v5, rdy5;

  assign rdy4 = !v4 || rdy5;
  assign div_rdy[T_BITS] = rdy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= div_v[T_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && div_v[T_BITS]) begin
      for (int i = 0; i < 3; i++) begin
        s4_a[i]    <= dv_a[i];
        s4_p[i]    <= dv_p[i];
        s4_prod[i] <= PRW'(dv_ab[i]) * PRW'(signed'({1'b0, dv_t}));
      end
      s4_t <= dv_t;
    end
  end

  // ---------------- stage 5: closest point and delta ----------------
  logic signed [PRW-1:0] s4_shr [3];
  logic signed [NW-1:0]  s4_nr  [3];
  logic signed [NW-1:0]  s4_dl  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_shr[i] = s4_prod[i] >>> T_BITS;
      s4_nr[i]  = NW'(s4_a[i]) + NW'(s4_shr[i]);
      s4_dl[i]  = NW'(s4_p[i]) - s4_nr[i];
    end
  end

  logic signed [CW-1:0]  s5_nr [3];
  logic signed [NW-1:0]  s5_dl [3];
  logic [TW-1:0]         s5_t;
  logic                  v6, rdy6;

  assign rdy5 = !v5 || rdy6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (rdy5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      for (int i = 0; i < 3; i++) begin
        s5_nr[i] <= s4_nr[i][CW-1:0];
        s5_dl[i] <= s4_dl[i];
      end
      s5_t <= s4_t;
    end
  end

  // ---------------- stage 6: squared deltas ----------------
  logic signed [CW-1:0]   s6_nr [3];
  logic signed [2*NW-1:0] s6_sq [3];
  logic [TW-1:0]          s6_t;
  logic                   v7, rdy7;

  assign rdy6 = !v6 || rdy7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (rdy6) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6 && v5) begin
      for (int i = 0; i < 3; i++) begin
        s6_nr[i] <= s5_nr[i];
        s6_sq[i] <= s5_dl[i] * s5_dl[i];
      end
      s6_t <= s5_t;
    end
  end

  // ---------------- stage 7: squared distance ----------------
  logic signed [CW-1:0] s7_nr [3];
  logic [XW-1:0]        s7_d2;
  logic [TW-1:0]        s7_t;

  logic          sq_v    [RW+1];
  logic          sq_rdy  [RW+1];
  logic [XW-1:0] sq_x    [RW+1];
  logic [RW-1:0] sq_root [RW+1];
  logic [EW-1:0] sq_rem  [RW+1];
  logic [SSW-1:0] sq_side [RW+1];

  assign rdy7 = !v7 || sq_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (rdy7) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy7 && v6) begin
      for (int i = 0; i < 3; i++) begin
        s7_nr[i] <= s6_nr[i];
      end
      s7_d2 <= s6_sq[0][XW-1:0] + s6_sq[1][XW-1:0] + s6_sq[2][XW-1:0];
      s7_t  <= s6_t;
    end
  end

  assign sq_v[0]    = v7;
  assign sq_x[0]    = s7_d2;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_side[0] = {s7_t, s7_nr[0], s7_nr[1], s7_nr[2], s7_d2};

  // ---------------- root chain: one root bit per cell ----------------
  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    psd_sqrt_cell #(
      .XW (XW),
      .SW (SSW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_v[g]),
      .in_ready  (sq_rdy[g]),
      .in_x      (sq_x[g]),
      .in_root   (sq_root[g]),
      .in_rem    (sq_rem[g]),
      .in_side   (sq_side[g]),
      .out_valid (sq_v[g+1]),
      .out_ready (sq_rdy[g+1]),
      .out_x     (sq_x[g+1]),
      .out_root  (sq_root[g+1]),
      .out_rem   (sq_rem[g+1]),
      .out_side  (sq_side[g+1])
    );
  end

  // Last root cell is the output register
  assign out_valid    = sq_v[RW];
  assign sq_rdy[RW]   = !out_stall;
  assign dist_root    = sq_root[RW];
  assign {param_t, near_x, near_y, near_z, dist_squared} = sq_side[RW];

  // ---------------- checks ----------------
  a_t_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (param_t <= (TW'(1) << T_BITS)))
    else $error("t above one");

  a_root_low: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((2*XW)'(dist_root) * (2*XW)'(dist_root) <= (2*XW)'(dist_squared)))
    else $error("root too large");

  a_root_high: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (((2*XW)'(dist_root) + 1) * ((2*XW)'(dist_root) + 1)
                   > (2*XW)'(dist_squared)))
    else $error("root too small");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");

endmodule

// ===== test/point_segment_closest_distance_unit_tb.sv =====
// Testbench for the point-to-segment closest distance unit: random and directed queries.
`timescale 1ns / 1ps

module point_segment_closest_distance_unit_tb;

  localparam int CB = psd_pkg::COORD_BITS_DEF;
  localparam int TB = psd_pkg::T_BITS_DEF;
  localparam int LATENCY = TB + CB + 8;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    logic [TB:0]       t;
    coord_t            nx;
    coord_t            ny;
    coord_t            nz;
    logic [2*CB+1:0]   d2;
    logic [CB:0]       root;
  } closest_t;

  // Expected-result store and checker
  class closest_scoreboard;
    closest_t pending[$];
    int errors;
    int checked;

    function logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // Work out the closest point for one request and queue it
    function void note_request(coord_t ax, coord_t ay, coord_t az, coord_t bx, coord_t by,
                               coord_t bz, coord_t px, coord_t py, coord_t pz);
      longint a[3], ab[3], ap[3], pr[3], nr[3];
      longint lensq, dotp, prod, delta;
      logic [63:0] tq, r, d2;
      closest_t e;
      a = '{ax, ay, az};
      ab = '{bx - ax, by - ay, bz - az};
      pr = '{px, py, pz};
      lensq = 0;
      dotp = 0;
      for (int i = 0; i < 3; i++) begin
        ap[i] = pr[i] - a[i];
        lensq += ab[i] * ab[i];
        dotp += ap[i] * ab[i];
      end
      tq = 0;
      if (lensq <= 0 || dotp <= 0) tq = 0;
      else if (dotp >= lensq) tq = 64'd1 << TB;
      else begin
        r = dotp;
        for (int i = 0; i < TB; i++) begin
          r = r << 1;
          tq = tq << 1;
          if (r >= lensq) begin
            r = r - lensq;
            tq[0] = 1'b1;
          end
        end
      end
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
        prod = ab[i] * longint'(tq);
        nr[i] = a[i] + (prod >>> TB);  // arithmetic shift is floor division
        delta = pr[i] - nr[i];
        d2 += delta * delta;
      end
      e.t = tq[TB:0];
      e.nx = nr[0][CB-1:0];
      e.ny = nr[1][CB-1:0];
      e.nz = nr[2][CB-1:0];
      e.d2 = d2[2*CB+1:0];
      e.root = (CB+1)'(floor_sqrt(d2));
      pending.push_back(e);
    endfunction

    function void check_result(closest_t got);
      closest_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.t !== e.t) begin
        $display("%0t: param_t exp %0d got %0d", $time, e.t, got.t); errors++;
      end
      if (got.nx !== e.nx) begin
        $display("%0t: near_x exp %0d got %0d", $time, e.nx, got.nx); errors++;
      end
      if (got.ny !== e.ny) begin
        $display("%0t: near_y exp %0d got %0d", $time, e.ny, got.ny); errors++;
      end
      if (got.nz !== e.nz) begin
        $display("%0t: near_z exp %0d got %0d", $time, e.nz, got.nz); errors++;
      end
      if (got.d2 !== e.d2) begin
        $display("%0t: dist_squared exp %0d got %0d", $time, e.d2, got.d2); errors++;
      end
      if (got.root !== e.root) begin
        $display("%0t: dist_root exp %0d got %0d", $time, e.root, got.root); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  coord_t end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z;
  coord_t query_x, query_y, query_z;
  logic [TB:0] param_t;
  coord_t near_x, near_y, near_z;
  logic [2*CB+1:0] dist_squared;
  logic [CB:0] dist_root;

  closest_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  bit hold_recv;
  int quiet_cycles;
  int sent;

  point_segment_closest_distance_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .end_a_x(end_a_x), .end_a_y(end_a_y), .end_a_z(end_a_z),
    .end_b_x(end_b_x), .end_b_y(end_b_y), .end_b_z(end_b_z),
    .query_x(query_x), .query_y(query_y), .query_z(query_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .param_t(param_t), .near_x(near_x), .near_y(near_y), .near_z(near_z),
    .dist_squared(dist_squared), .dist_root(dist_root)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Accepted requests and results are sampled at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_request(end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z,
                        query_x, query_y, query_z);
      if (out_valid && !out_stall)
        sb.check_result({param_t, near_x, near_y, near_z, dist_squared, dist_root});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver stall, random or held
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(4095)) - 2048);
      default: return coord_t'($urandom_range(1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}});
    endcase
  endfunction

  // Offer one request and hold it until taken
  task automatic send_query(coord_t ax, coord_t ay, coord_t az, coord_t bx, coord_t by,
                            coord_t bz, coord_t px, coord_t py, coord_t pz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    end_a_x <= ax; end_a_y <= ay; end_a_z <= az;
    end_b_x <= bx; end_b_y <= by; end_b_z <= bz;
    query_x <= px; query_y <= py; query_z <= pz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_random;
    coord_t ax, ay, az, bx, by, bz;
    int mode;
    mode = $urandom_range(9);
    mode = (mode < 4) ? 0 : (mode < 9) ? 1 : 2;
    ax = rand_coord(mode); ay = rand_coord(mode); az = rand_coord(mode);
    case ($urandom_range(9))
      0: begin bx = ax; by = ay; bz = az; end  // degenerate segment
      1: begin bx = ax + 1; by = ay; bz = az; end
      default: begin bx = rand_coord(mode); by = rand_coord(mode); bz = rand_coord(mode); end
    endcase
    send_query(ax, ay, az, bx, by, bz, rand_coord(mode), rand_coord(mode), rand_coord(mode));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  localparam coord_t CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CB-1){1'b0}}};

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    hold_recv = 1'b0;
    quiet_cycles = 0;
    sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    {end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z} = '0;
    {query_x, query_y, query_z} = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: degenerate, before A, beyond B, interior, extremes
    send_query(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_query(100, -5, 7, 100, -5, 7, CMAX, CMIN, CMAX);
    send_query(0, 0, 0, 1024, 0, 0, -300, 50, 9);
    send_query(0, 0, 0, 1024, 0, 0, 0, 77, 0);
    send_query(0, 0, 0, 1024, 0, 0, 1024, 5, 5);
    send_query(0, 0, 0, 1024, 0, 0, 5000, 0, 0);
    send_query(0, 0, 0, 1024, 0, 0, 333, -12, 40);
    send_query(0, 0, 0, 3, 0, 0, 1, 0, 0);
    send_query(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0);
    send_query(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN);
    send_query(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    send_query(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX);
    send_query(-1, -1, -1, 2, -3, 5, 1, -1, 2);
    send_query(-7, 3, 0, 9, -1, 4, 17, 30, -2);
    send_query(0, 0, 0, -1, -1, -1, 0, 0, 0);
    drain();

    // Back pressure: hold the receiver for a stretch while the sender keeps offering
    fork
      repeat (120) send_random();
      begin
        hold_recv = 1'b1;
        repeat (150) @(posedge clk);
        hold_recv = 1'b0;
      end
    join
    drain();

    send_idle_pct = 13; recv_idle_pct = 69;
    repeat (450) send_random();
    drain();  // sender pauses until all results are back
    send_idle_pct = 69; recv_idle_pct = 13;
    repeat (450) send_random();
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (370) send_random();
    drain();
    repeat (LATENCY + 10) @(posedge clk);

    $display("Ran %0d queries, %0d results checked, with degenerate, clamped, interior",
             sent, sb.checked);
    $display("and extreme segments under random and held stalls on both sides.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/psd_pkg.sv
rtl/psd_div_cell.sv
rtl/psd_sqrt_cell.sv
rtl/point_segment_closest_distance_unit.sv
test/point_segment_closest_distance_unit_tb.sv
